@@ rtl/pll_clock_divider_solver_assert.svh @@
// assertion macros for the clock plan solver
// used by pll_clock_divider_solver.sv; expects clk and rst_n in scope
`ifndef PLL_CLOCK_DIVIDER_SOLVER_ASSERT_SVH
`define PLL_CLOCK_DIVIDER_SOLVER_ASSERT_SVH
`ifndef SYNTHESIS
`define PCDS_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define PCDS_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define PCDS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define PCDS_ASSERT(lbl, cond, msg)
`define PCDS_ASSERT_IMP(lbl, ante, cons, msg)
`define PCDS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/pllcds_pkg.sv @@
// types, constants and helpers for the clock plan solver
// no dependencies; imported by pll_clock_divider_solver
`timescale 1ns / 1ps

package pllcds_pkg;

    localparam int FLASH_WAIT_LEVELS_DEF = 2;

    localparam int PLL_SYS_MIN   = 16;
    localparam int PLL_MUL_MIN   = 2;
    localparam int PLL_MUL_MAX   = 16;
    localparam int FLASH_STEP    = 24;
    localparam int KHZ_PER_MHZ   = 1000;
    localparam int AHB_SHIFT_MAX = 8;

    // 2^26 / 1000 rounded up, exact floor for 16 bit operands
    localparam int RECIP_1000 = 67109;
    localparam int RECIP_SHIFT = 26;

    localparam logic [6:0] OSC_RESET  = 7'd8;
    localparam logic [4:0] PMIN_RESET = 5'd1;
    localparam logic [4:0] PMAX_RESET = 5'd16;

    typedef enum logic [1:0] {
        CFG_OSC  = 2'd0,
        CFG_PMIN = 2'd1,
        CFG_PMAX = 2'd2
    } cfg_index_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_PLL_START,
        S_GCD,
        S_DIV,
        S_SCALE,
        S_CHECK,
        S_SHIFT,
        S_INT_MHZ,
        S_DONE
    } state_t;

    typedef struct packed {
        logic [15:0] source_khz;
        logic [15:0] target_freq;
        logic        use_khz;
        logic        pll_request;
    } in_t;

    typedef struct packed {
        logic        use_pll;
        logic [11:0] pll_mul;
        logic [11:0] pll_div;
        logic [3:0]  ahb_shift;
        logic        flash_wait;
        logic [15:0] achieved_freq;
        logic        config_error;
    } out_t;

    // floor(x / 1000) by reciprocal multiply
    function automatic logic [6:0] div1000(input logic [15:0] x);
        logic [32:0] prod;
        prod = 33'(x) * 33'(RECIP_1000);
        return prod[RECIP_SHIFT+6:RECIP_SHIFT];
    endfunction

endpackage

@@ rtl/pll_clock_divider_solver.sv @@
// clock plan solver top level: sequencer and shared datapath
// depends on pllcds_pkg and pll_clock_divider_solver_assert.svh
`timescale 1ns / 1ps

// Clock plan solver. One item at a time: in_ready is high only while idle.
// Internal oscillator items try one shift per cycle. PLL items walk the
// target downward from min(target, 16 * source MHz) and spend per candidate
// one binary gcd (one step a cycle), two restoring divisions, scaling and
// one check; a fully failing search walks up to roughly 1000 candidates.
// A finished result waits in the output register until taken.
module pll_clock_divider_solver #(
    parameter int FLASH_WAIT_LEVELS = pllcds_pkg::FLASH_WAIT_LEVELS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pllcds_pkg::in_t   in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output pllcds_pkg::out_t  out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [6:0]        cfg_data
);
    import pllcds_pkg::*;

    localparam int DIV_BITS = 11;
    localparam logic [3:0] DIV_LAST = 4'(DIV_BITS - 1);

    state_t state_reg, state_next;

    logic [6:0]  osc_reg;
    logic [4:0]  pmin_reg;
    logic [4:0]  pmax_reg;

    in_t         in_hold_reg, in_hold_next;
    logic [6:0]  base_reg, base_next;
    logic [16:0] ibase_reg, ibase_next;
    logic [10:0] t_reg, t_next;
    logic [10:0] ga_reg, ga_next;
    logic [10:0] gb_reg, gb_next;
    logic [2:0]  twos_reg, twos_next;
    logic [6:0]  g_reg, g_next;
    logic [10:0] dv_num_reg, dv_num_next;
    logic [7:0]  dv_rem_reg, dv_rem_next;
    logic [10:0] dv_q_reg, dv_q_next;
    logic [3:0]  dv_cnt_reg, dv_cnt_next;
    logic        dv_sel_reg, dv_sel_next;
    logic [10:0] m_reg, m_next;
    logic [10:0] d_reg, d_next;
    logic [15:0] mk_reg, mk_next;
    logic [15:0] dk_reg, dk_next;
    logic [3:0]  sh_reg, sh_next;
    logic [15:0] freq_reg, freq_next;
    logic [10:0] mhz_reg, mhz_next;
    logic        pll_reg, pll_next;
    logic        err_reg, err_next;
    out_t        out_reg, out_next;
    logic        out_valid_reg, out_valid_next;

    // shared combinational pieces
    logic [15:0] mul_arg;
    logic [6:0]  q1000;
    logic        pll_path;
    logic        gcd_done;
    logic [7:0]  rem_sh;
    logic        rem_ge;
    logic [10:0] q_new;
    logic        scale_more;
    logic        check_fail;
    logic [15:0] t_cap;
    logic [16:0] shifted;
    logic        shift_hit;
    logic        can_load;
    logic        flash_bit;

    assign mul_arg = (state_reg == S_PREP) ? in_hold_reg.source_khz : freq_reg;
    assign q1000   = div1000(mul_arg);

    assign pll_path = !in_hold_reg.use_khz && in_hold_reg.pll_request
                      && (in_hold_reg.target_freq >= 16'(PLL_SYS_MIN));
    assign gcd_done = (ga_reg == gb_reg);
    assign rem_sh   = {dv_rem_reg[6:0], dv_num_reg[DIV_BITS-1]};
    assign rem_ge   = (rem_sh >= {1'b0, g_reg});
    assign q_new    = {dv_q_reg[DIV_BITS-2:0], rem_ge};
    assign scale_more = (mk_reg < 16'(PLL_MUL_MIN)) || (dk_reg < 16'(pmin_reg));
    assign check_fail = (mk_reg > 16'(PLL_MUL_MAX)) || (dk_reg > 16'(base_reg))
                        || (dk_reg > 16'(pmax_reg));
    assign t_cap    = {5'b0, base_reg, 4'b0};
    assign shifted  = ibase_reg >> sh_reg;
    assign shift_hit = (shifted <= {1'b0, in_hold_reg.target_freq})
                       || (sh_reg == 4'(AHB_SHIFT_MAX));
    assign can_load = !out_valid_reg || out_ready;

    // flash wait states from the clock in MHz
    always_comb
    begin
        int  lvl;
        logic found;
        lvl   = FLASH_WAIT_LEVELS - 1;
        found = 1'b0;
        for (int w = 1; w <= FLASH_WAIT_LEVELS; w++)
        begin
            if (!found && (32'(mhz_reg) <= 32'(FLASH_STEP * w)))
            begin
                lvl   = w - 1;
                found = 1'b1;
            end
        end
        flash_bit = lvl[0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:      if (in_valid) state_next = S_PREP;
            S_PREP:      state_next = pll_path ? S_PLL_START : S_SHIFT;
            S_PLL_START: state_next = (base_reg == 7'd0) ? S_DONE : S_GCD;
            S_GCD:       if (gcd_done) state_next = S_DIV;
            S_DIV:       if (dv_cnt_reg == DIV_LAST && dv_sel_reg) state_next = S_SCALE;
            S_SCALE:     if (!scale_more) state_next = S_CHECK;
            S_CHECK:
            begin
                if (!check_fail || t_reg == 11'(PLL_SYS_MIN))
                    state_next = S_DONE;
                else
                    state_next = S_GCD;
            end
            S_SHIFT:     if (shift_hit) state_next = S_INT_MHZ;
            S_INT_MHZ:   state_next = S_DONE;
            S_DONE:      if (can_load) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb
    begin
        in_ready  = (state_reg == S_IDLE);
        cfg_ready = 1'b1;
        out_valid = out_valid_reg;
        out_data  = out_reg;
    end

    // datapath
    always_comb
    begin
        in_hold_next = in_hold_reg;
        base_next    = base_reg;
        ibase_next   = ibase_reg;
        t_next       = t_reg;
        ga_next      = ga_reg;
        gb_next      = gb_reg;
        twos_next    = twos_reg;
        g_next       = g_reg;
        dv_num_next  = dv_num_reg;
        dv_rem_next  = dv_rem_reg;
        dv_q_next    = dv_q_reg;
        dv_cnt_next  = dv_cnt_reg;
        dv_sel_next  = dv_sel_reg;
        m_next       = m_reg;
        d_next       = d_reg;
        mk_next      = mk_reg;
        dk_next      = dk_reg;
        sh_next      = sh_reg;
        freq_next    = freq_reg;
        mhz_next     = mhz_reg;
        pll_next     = pll_reg;
        err_next     = err_reg;
        out_next     = out_reg;
        out_valid_next = out_valid_reg && !out_ready;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                    in_hold_next = in_data;
            end
            S_PREP:
            begin
                base_next  = q1000;
                ibase_next = in_hold_reg.use_khz ? 17'(osc_reg) * 17'(KHZ_PER_MHZ)
                                                 : 17'(osc_reg);
                sh_next    = 4'd0;
                err_next   = 1'b0;
                pll_next   = 1'b0;
            end
            S_PLL_START:
            begin
                pll_next = 1'b1;
                if (base_reg == 7'd0)
                    err_next = 1'b1;
                t_next    = (in_hold_reg.target_freq < t_cap)
                            ? in_hold_reg.target_freq[10:0] : t_cap[10:0];
                ga_next   = (in_hold_reg.target_freq < t_cap)
                            ? in_hold_reg.target_freq[10:0] : t_cap[10:0];
                gb_next   = {4'b0, base_reg};
                twos_next = 3'd0;
            end
            S_GCD:
            begin
                if (gcd_done)
                begin
                    g_next      = 7'(ga_reg << twos_reg);
                    dv_num_next = t_reg;
                    dv_rem_next = 8'd0;
                    dv_q_next   = '0;
                    dv_cnt_next = 4'd0;
                    dv_sel_next = 1'b0;
                end
                else if (!ga_reg[0] && !gb_reg[0])
                begin
                    ga_next   = ga_reg >> 1;
                    gb_next   = gb_reg >> 1;
                    twos_next = twos_reg + 3'd1;
                end
                else if (!ga_reg[0])
                    ga_next = ga_reg >> 1;
                else if (!gb_reg[0])
                    gb_next = gb_reg >> 1;
                else if (ga_reg > gb_reg)
                    ga_next = ga_reg - gb_reg;
                else
                    gb_next = gb_reg - ga_reg;
            end
            S_DIV:
            begin
                // restoring division, one quotient bit a cycle
                dv_rem_next = rem_ge ? (rem_sh - {1'b0, g_reg}) : rem_sh;
                dv_q_next   = q_new;
                dv_num_next = dv_num_reg << 1;
                dv_cnt_next = dv_cnt_reg + 4'd1;
                if (dv_cnt_reg == DIV_LAST)
                begin
                    if (!dv_sel_reg)
                    begin
                        m_next      = q_new;
                        dv_num_next = {4'b0, base_reg};
                        dv_rem_next = 8'd0;
                        dv_q_next   = '0;
                        dv_cnt_next = 4'd0;
                        dv_sel_next = 1'b1;
                    end
                    else
                    begin
                        d_next  = q_new;
                        mk_next = 16'(m_reg);
                        dk_next = 16'(q_new);
                    end
                end
            end
            S_SCALE:
            begin
                if (scale_more)
                begin
                    mk_next = mk_reg + 16'(m_reg);
                    dk_next = dk_reg + 16'(d_reg);
                end
            end
            S_CHECK:
            begin
                if (!check_fail)
                begin
                    mhz_next  = t_reg;
                    freq_next = 16'(t_reg);
                end
                else if (t_reg == 11'(PLL_SYS_MIN))
                    err_next = 1'b1;
                else
                begin
                    t_next    = t_reg - 11'd1;
                    ga_next   = t_reg - 11'd1;
                    gb_next   = {4'b0, base_reg};
                    twos_next = 3'd0;
                end
            end
            S_SHIFT:
            begin
                if (shift_hit)
                    freq_next = shifted[15:0];
                else
                    sh_next = sh_reg + 4'd1;
            end
            S_INT_MHZ:
            begin
                mhz_next = in_hold_reg.use_khz ? 11'(q1000) : freq_reg[10:0];
            end
            S_DONE:
            begin
                if (can_load)
                begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    if (err_reg)
                        out_next.config_error = 1'b1;
                    else
                    begin
                        out_next.use_pll       = pll_reg;
                        out_next.pll_mul       = pll_reg ? mk_reg[11:0] : 12'd0;
                        out_next.pll_div       = pll_reg ? dk_reg[11:0] : 12'd0;
                        out_next.ahb_shift     = pll_reg ? 4'd0 : sh_reg;
                        out_next.flash_wait    = flash_bit;
                        out_next.achieved_freq = freq_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            osc_reg       <= OSC_RESET;
            pmin_reg      <= PMIN_RESET;
            pmax_reg      <= PMAX_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_OSC:  osc_reg  <= cfg_data;
                    CFG_PMIN: pmin_reg <= cfg_data[4:0];
                    CFG_PMAX: pmax_reg <= cfg_data[4:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        in_hold_reg <= in_hold_next;
        base_reg    <= base_next;
        ibase_reg   <= ibase_next;
        t_reg       <= t_next;
        ga_reg      <= ga_next;
        gb_reg      <= gb_next;
        twos_reg    <= twos_next;
        g_reg       <= g_next;
        dv_num_reg  <= dv_num_next;
        dv_rem_reg  <= dv_rem_next;
        dv_q_reg    <= dv_q_next;
        dv_cnt_reg  <= dv_cnt_next;
        dv_sel_reg  <= dv_sel_next;
        m_reg       <= m_next;
        d_reg       <= d_next;
        mk_reg      <= mk_next;
        dk_reg      <= dk_next;
        sh_reg      <= sh_next;
        freq_reg    <= freq_next;
        mhz_reg     <= mhz_next;
        pll_reg     <= pll_next;
        err_reg     <= err_next;
        out_reg     <= out_next;
    end

`include "pll_clock_divider_solver_assert.svh"

    `PCDS_ASSERT_IMP(a_gcd_nonzero, state_reg == S_GCD, ga_reg != 11'd0 && gb_reg != 11'd0, "gcd operand is zero")
    `PCDS_ASSERT_IMP(a_div_nonzero, state_reg == S_DIV, g_reg != 7'd0, "division by zero gcd")
    `PCDS_ASSERT_NEXT(a_accept_prep, in_valid && in_ready, state_reg == S_PREP, "accepted item did not start")
    `PCDS_ASSERT_IMP(a_pll_mul_range, out_valid_reg && out_reg.use_pll, out_reg.pll_mul >= 12'd2 && out_reg.pll_mul <= 12'd16, "pll multiplier out of range")
    `PCDS_ASSERT_IMP(a_err_clean, out_valid_reg && out_reg.config_error, !out_reg.use_pll && out_reg.achieved_freq == 16'd0, "error result not cleared")

endmodule

@@ bench/tb.sv @@
// self-checking bench for the clock plan solver: directed then random requests
// depends on pllcds_pkg and pll_clock_divider_solver
`timescale 1ns / 1ps

module tb;
    import pllcds_pkg::*;

    localparam int WAIT_LEVELS = 2;
    localparam int STALL_LIMIT = 400000;
    localparam int RANDOM_PER_PHASE = 250;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    // scoreboard for clock plans still owed by the block
    class plan_board;
        out_t pending[$];
        int   mismatches;
        int   plans_checked;

        function void note(out_t plan);
            pending.push_back(plan);
        endfunction

        function void check(out_t got);
            out_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected plan %p", got);
                return;
            end
            want = pending.pop_front();
            plans_checked++;
            if (got.use_pll !== want.use_pll || got.pll_mul !== want.pll_mul ||
                got.pll_div !== want.pll_div || got.ahb_shift !== want.ahb_shift ||
                got.flash_wait !== want.flash_wait ||
                got.achieved_freq !== want.achieved_freq ||
                got.config_error !== want.config_error)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("plan mismatch: expected %p got %p", want, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    in_t  in_data;
    logic out_valid;
    logic out_ready;
    out_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [1:0] cfg_index;
    logic [6:0] cfg_data;

    logic [6:0] osc_mhz;
    logic [4:0] pdiv_min;
    logic [4:0] pdiv_max;
    int sender_idle;
    int receiver_idle;
    int stall_count;
    int pll_plans;
    int error_plans;
    plan_board board;

    pll_clock_divider_solver dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int unsigned common_factor(int unsigned a, int unsigned b);
        int unsigned r;
        while (b != 0)
        begin
            r = a % b;
            a = b;
            b = r;
        end
        return a;
    endfunction

    function automatic logic flash_for(int unsigned mhz);
        int unsigned w;
        for (w = 1; w <= WAIT_LEVELS; w++)
            if (mhz <= FLASH_STEP * w)
                return 1'((w - 1));
        return 1'((WAIT_LEVELS - 1));
    endfunction

    function automatic out_t plan_for(in_t req);
        out_t p;
        int unsigned src_mhz, t, g, m, d, k, kd, scale, osc, sh;
        bit found;
        p = '0;
        found = 0;
        if (!req.use_khz && req.pll_request && req.target_freq >= PLL_SYS_MIN)
        begin
            src_mhz = req.source_khz / KHZ_PER_MHZ;
            t = req.target_freq;
            if (src_mhz != 0)
            begin
                while (t >= PLL_SYS_MIN && !found)
                begin
                    g = common_factor(t, src_mhz);
                    m = t / g;
                    d = src_mhz / g;
                    k = 1;
                    if (m < PLL_MUL_MIN)
                        k = (PLL_MUL_MIN + m - 1) / m;
                    if (d < pdiv_min)
                    begin
                        kd = (pdiv_min + d - 1) / d;
                        if (kd > k)
                            k = kd;
                    end
                    m *= k;
                    d *= k;
                    if (m <= PLL_MUL_MAX && d <= src_mhz && d <= pdiv_max)
                        found = 1;
                    else
                        t--;
                end
            end
            if (found)
            begin
                p.use_pll = 1'b1;
                p.pll_mul = 12'(m);
                p.pll_div = 12'(d);
                p.achieved_freq = 16'(t);
                p.flash_wait = flash_for(t);
            end
            else
                p.config_error = 1'b1;
        end
        else
        begin
            scale = req.use_khz ? KHZ_PER_MHZ : 1;
            osc = osc_mhz * scale;
            for (sh = 0; sh < AHB_SHIFT_MAX; sh++)
                if ((osc >> sh) <= req.target_freq)
                    break;
            p.ahb_shift = 4'(sh);
            p.achieved_freq = 16'(osc >> sh);
            p.flash_wait = flash_for((osc >> sh) / scale);
        end
        return p;
    endfunction

    // acceptance monitor: register writes, requests and plans
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_OSC:  osc_mhz <= cfg_data;
                    CFG_PMIN: pdiv_min <= cfg_data[4:0];
                    CFG_PMAX: pdiv_max <= cfg_data[4:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                board.note(plan_for(in_data));
            end
            if (out_valid && out_ready)
            begin
                board.check(out_data);
                if (out_data.use_pll)
                    pll_plans++;
                if (out_data.config_error)
                    error_plans++;
            end
            if ((in_valid && in_ready) || (out_valid && out_ready) ||
                (cfg_valid && cfg_ready))
                stall_count <= 0;
            else
                stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= ($urandom_range(99, 0) >= receiver_idle);
    end

    task automatic send_request(in_t req);
        if ($urandom_range(99, 0) < sender_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99, 0) < sender_idle)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [6:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic in_t make_req(logic [15:0] src, logic [15:0] tgt,
                                     logic khz, logic pll);
        in_t r;
        r.source_khz = src;
        r.target_freq = tgt;
        r.use_khz = khz;
        r.pll_request = pll;
        return r;
    endfunction

    // restrictive predivider limits make failing searches long, so keep targets low
    function automatic in_t random_req(bit tight);
        int unsigned pick;
        pick = $urandom_range(99, 0);
        if (pick < 65)
        begin
            if (tight)
                return make_req(16'($urandom_range(65535, 1000)),
                                16'($urandom_range(40, 16)), 1'b0, 1'b1);
            else if ($urandom_range(9, 0) == 0)
                return make_req(16'($urandom_range(65535, 1000)),
                                16'($urandom_range(300, 16)), 1'b0, 1'b1);
            else
                return make_req(16'($urandom_range(65535, 1000)),
                                16'($urandom_range(64, 16)), 1'b0, 1'b1);
        end
        else if (pick < 80)
            return make_req(16'($urandom), 16'($urandom_range(80, 0)), 1'b0, 1'b0);
        else if (pick < 92)
            return make_req(16'($urandom), 16'($urandom), 1'b1, 1'($urandom));
        else
            return make_req(16'($urandom), 16'($urandom), 1'b0,
                            tight ? 1'b0 : 1'($urandom));
    endfunction

    initial
    begin
        logic [6:0] osc_set [6];
        logic [6:0] pmin_set [6];
        logic [6:0] pmax_set [6];
        int phase;
        int n;
        bit tight;

        osc_set  = '{7'd8, 7'd64, 7'd1, 7'd37, 7'd5, 7'd24};
        pmin_set = '{7'd1, 7'd16, 7'd1, 7'd3, 7'd12, 7'd2};
        pmax_set = '{7'd16, 7'd16, 7'd1, 7'd9, 7'd4, 7'd13};
        board = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_OSC;
        cfg_data = '0;
        osc_mhz = OSC_RESET;
        pdiv_min = PMIN_RESET;
        pdiv_max = PMAX_RESET;
        sender_idle = 6;
        receiver_idle = 76;
        stall_count = 0;
        pll_plans = 0;
        error_plans = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset values first, then the directed corners
        send_request(make_req(16'd12000, 16'd48, 1'b0, 1'b1));
        send_request(make_req(16'd0, 16'd20, 1'b0, 1'b1));
        send_request(make_req(16'd999, 16'd16, 1'b0, 1'b1));
        send_request(make_req(16'd65535, 16'd65535, 1'b0, 1'b1));
        send_request(make_req(16'd8000, 16'd15, 1'b0, 1'b1));
        send_request(make_req(16'd8000, 16'd16, 1'b0, 1'b1));
        send_request(make_req(16'd1000, 16'd17, 1'b0, 1'b1));
        send_request(make_req(16'd25000, 16'd24, 1'b0, 1'b1));
        send_request(make_req(16'd25000, 16'd25, 1'b0, 1'b1));
        send_request(make_req(16'd8000, 16'd0, 1'b0, 1'b0));
        send_request(make_req(16'd8000, 16'd65535, 1'b0, 1'b0));
        send_request(make_req(16'd8000, 16'd4, 1'b0, 1'b0));
        send_request(make_req(16'd8000, 16'd0, 1'b1, 1'b1));
        send_request(make_req(16'd8000, 16'd8000, 1'b1, 1'b1));
        send_request(make_req(16'd8000, 16'd65535, 1'b1, 1'b0));
        send_request(make_req(16'd8000, 16'd31, 1'b1, 1'b0));
        drain();
        write_reg(CFG_UNUSED, 7'h7F);
        write_reg(CFG_OSC, 7'd64);
        send_request(make_req(16'd8000, 16'd63, 1'b0, 1'b0));
        send_request(make_req(16'd8000, 16'd65535, 1'b1, 1'b0));
        send_request(make_req(16'd8000, 16'd0, 1'b1, 1'b0));
        drain();
        write_reg(CFG_PMIN, 7'd9);
        write_reg(CFG_PMAX, 7'd3);
        // predivider maximum under the minimum
        send_request(make_req(16'd12000, 16'd20, 1'b0, 1'b1));
        drain();

        for (phase = 0; phase < 6; phase++)
        begin
            write_reg(CFG_OSC, osc_set[phase]);
            write_reg(CFG_PMIN, pmin_set[phase]);
            write_reg(CFG_PMAX, pmax_set[phase]);
            if (phase < 2)
            begin
                sender_idle = 6;
                receiver_idle = 76;
            end
            else if (phase < 4)
            begin
                sender_idle = 76;
                receiver_idle = 6;
            end
            else
            begin
                sender_idle = 0;
                receiver_idle = 0;
            end
            tight = (pmin_set[phase] > pmax_set[phase]) || (pmin_set[phase] > 8) ||
                    (pmax_set[phase] < 4);
            for (n = 0; n < RANDOM_PER_PHASE; n++)
                send_request(random_req(tight));
            drain();
        end

        repeat (50) @(posedge clk);
        $display("checked %0d clock plans: %0d through the pll, %0d search failures",
                 board.plans_checked, pll_plans, error_plans);
        $display("six register settings, three handshake idling patterns");
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
